// ----- rtl/afc_pkg.sv -----
// ----------------------------------------------------------------------------
// afc_pkg
// shared types and constants of the box versus frustum culling pipeline
// ----------------------------------------------------------------------------
package afc_pkg;

    // field formats
    localparam int COORD_W   = 24;            // Q16.8 box coordinate
    localparam int NORM_W    = 12;            // Q2.10 normal component
    localparam int D_W       = 28;            // Q20.8 plane offset
    localparam int D_SHIFT   = 10;            // aligns d to 18 fraction bits
    localparam int PROD_W    = COORD_W + NORM_W;
    localparam int SUM_W     = PROD_W + 3;    // three products plus d, exact
    localparam int PLANE_W   = 64;
    localparam int NUM_AXES  = 3;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int COUNT_W    = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANES_USED = 3'd6;
    localparam logic [COUNT_W-1:0]   PLANES_USED_RST = 3'd6;
    localparam int MAX_PLANES_DEF = 6;

    // result codes
    typedef enum logic [1:0] {
        CLASS_INSIDE  = 2'd0,
        CLASS_CUT     = 2'd1,
        CLASS_OUTSIDE = 2'd2
    } clip_class_t;

    // one box word
    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
    } box_t;

    // per plane test outcome
    typedef struct packed {
        logic outside;
        logic cut;
    } lane_flags_t;

endpackage

// ----- rtl/aabb_frustum_cull.sv -----
// ----------------------------------------------------------------------------
// aabb_frustum_cull
// classifies a box against the leading frustum planes: inside, cut, outside
// ----------------------------------------------------------------------------
// result: done rises for one cycle, with the result word valid beside it, once the
//   word has passed the box, product, sum and flag registers and the done register
// throughput: one box word per cycle, busy stays low; the multiply, sum and
//   compare stages of the per plane lanes are each registered
// reset: planes clear to zero, plane count returns to six, pipeline empties
// the receiver cannot stall, so the pipeline never holds
module aabb_frustum_cull #(
    parameter int MAX_PLANES = afc_pkg::MAX_PLANES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [afc_pkg::COORD_W-1:0] min_x,
    input  logic signed [afc_pkg::COORD_W-1:0] min_y,
    input  logic signed [afc_pkg::COORD_W-1:0] min_z,
    input  logic signed [afc_pkg::COORD_W-1:0] max_x,
    input  logic signed [afc_pkg::COORD_W-1:0] max_y,
    input  logic signed [afc_pkg::COORD_W-1:0] max_z,
    output logic                              done,
    output afc_pkg::clip_class_t              clip_class,
    input  logic                              cfg_we,
    input  logic [afc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [afc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import afc_pkg::*;

    localparam int LANE_LAT = 3;

    logic [PLANE_W-1:0]  plane_reg [MAX_PLANES];
    logic [COUNT_W-1:0]  planes_used_reg;
    box_t                box_reg;
    logic [LANE_LAT:0]   valid_reg;
    lane_flags_t         flags [MAX_PLANES];
    logic                outside_any;
    logic                cut_any;
    clip_class_t         class_next;
    clip_class_t         class_reg;
    logic                done_reg;

    // every word is taken, the pipeline never holds
    assign busy = 1'b0;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PLANES; i++)
            begin
                plane_reg[i] <= '0;
            end
            planes_used_reg <= PLANES_USED_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_PLANES_USED)
            begin
                planes_used_reg <= cfg_data[COUNT_W-1:0];
            end
            for (int i = 0; i < MAX_PLANES; i++)
            begin
                if (cfg_index == CFG_IDX_W'(i))
                begin
                    plane_reg[i] <= cfg_data[PLANE_W-1:0];
                end
            end
        end
    end

    // input stage: capture the box word
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            box_reg.min_x <= min_x;
            box_reg.min_y <= min_y;
            box_reg.min_z <= min_z;
            box_reg.max_x <= max_x;
            box_reg.max_y <= max_y;
            box_reg.max_z <= max_z;
        end
    end

    // valid bits travel alongside the lane stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[LANE_LAT-1:0], start && !busy};
            done_reg  <= valid_reg[LANE_LAT];
        end
    end

    // one lane per stored plane
    for (genvar g = 0; g < MAX_PLANES; g++)
    begin : g_lane
        afc_plane_lane u_lane (
            .clk   (clk),
            .box   (box_reg),
            .plane (plane_reg[g]),
            .flags (flags[g])
        );
    end

    // merge the lanes under the plane count
    always_comb
    begin
        outside_any = 1'b0;
        cut_any     = 1'b0;
        for (int i = 0; i < MAX_PLANES; i++)
        begin
            if (COUNT_W'(i) < planes_used_reg)
            begin
                outside_any = outside_any | flags[i].outside;
                cut_any     = cut_any | flags[i].cut;
            end
        end
        if (outside_any)
        begin
            class_next = CLASS_OUTSIDE;
        end
        else if (cut_any)
        begin
            class_next = CLASS_CUT;
        end
        else
        begin
            class_next = CLASS_INSIDE;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        class_reg <= class_next;
    end

    assign done       = done_reg;
    assign clip_class = class_reg;

    // each accepted word gives exactly one result strobe
    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##5 done)
        else $error("accepted word produced no result strobe");

    a_done_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 5))
        else $error("result strobe without an accepted word");

    a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (clip_class == CLASS_INSIDE || clip_class == CLASS_CUT ||
                  clip_class == CLASS_OUTSIDE))
        else $error("result carries an unused class code");

    a_no_planes: assert property (@(posedge clk) disable iff (!rst_n)
        (done && planes_used_reg == '0) |-> (clip_class == CLASS_INSIDE))
        else $error("no tested planes but box not inside");

endmodule

// ----- rtl/afc_plane_lane.sv -----
// ----------------------------------------------------------------------------
// afc_plane_lane
// three stage p/n-vertex test of one box against one plane
// ----------------------------------------------------------------------------
module afc_plane_lane (
    input  logic                         clk,
    input  afc_pkg::box_t                box,
    input  logic [afc_pkg::PLANE_W-1:0]  plane,
    output afc_pkg::lane_flags_t         flags
);
    import afc_pkg::*;

    logic signed [COORD_W-1:0] lo      [NUM_AXES];
    logic signed [COORD_W-1:0] hi      [NUM_AXES];
    logic signed [NORM_W-1:0]  norm    [NUM_AXES];
    logic signed [PROD_W-1:0]  nv_next [NUM_AXES];
    logic signed [PROD_W-1:0]  pv_next [NUM_AXES];
    logic signed [PROD_W-1:0]  nv_reg  [NUM_AXES];
    logic signed [PROD_W-1:0]  pv_reg  [NUM_AXES];
    logic signed [D_W-1:0]     d_reg;
    logic signed [SUM_W-1:0]   nv_sum_next;
    logic signed [SUM_W-1:0]   pv_sum_next;
    logic signed [SUM_W-1:0]   nv_sum_reg;
    logic signed [SUM_W-1:0]   pv_sum_reg;
    logic signed [SUM_W-1:0]   d_ext;
    lane_flags_t               flags_next;
    lane_flags_t               flags_reg;

    // stage one: corner choice by normal sign, then the products
    always_comb
    begin
        lo[0] = box.min_x;
        lo[1] = box.min_y;
        lo[2] = box.min_z;
        hi[0] = box.max_x;
        hi[1] = box.max_y;
        hi[2] = box.max_z;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            norm[a] = plane[a*NORM_W +: NORM_W];
            // zero counts as not positive
            if (!norm[a][NORM_W-1] && (norm[a] != '0))
            begin
                nv_next[a] = lo[a] * norm[a];
                pv_next[a] = hi[a] * norm[a];
            end
            else
            begin
                nv_next[a] = hi[a] * norm[a];
                pv_next[a] = lo[a] * norm[a];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            nv_reg[a] <= nv_next[a];
            pv_reg[a] <= pv_next[a];
        end
        d_reg <= plane[PLANE_W-1 -: D_W];
    end

    // stage two: exact sums with the aligned offset
    always_comb
    begin
        d_ext       = SUM_W'(d_reg) <<< D_SHIFT;
        nv_sum_next = SUM_W'(nv_reg[0]) + SUM_W'(nv_reg[1]) + SUM_W'(nv_reg[2]) + d_ext;
        pv_sum_next = SUM_W'(pv_reg[0]) + SUM_W'(pv_reg[1]) + SUM_W'(pv_reg[2]) + d_ext;
    end

    always_ff @(posedge clk)
    begin
        nv_sum_reg <= nv_sum_next;
        pv_sum_reg <= pv_sum_next;
    end

    // stage three: strictly positive means the outer side
    always_comb
    begin
        flags_next.outside = !nv_sum_reg[SUM_W-1] && (nv_sum_reg != '0);
        flags_next.cut     = !pv_sum_reg[SUM_W-1] && (pv_sum_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        flags_reg <= flags_next;
    end

    assign flags = flags_reg;

endmodule

// ----- tb/aabb_frustum_cull_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_frustum_cull_tb
// self-checking bench for the box versus frustum classifier: a queue-fed
// driver sends box words and plane writes, a clocked monitor predicts each
// class from its own copy of the planes and checks every done strobe in order
// ----------------------------------------------------------------------------
module aabb_frustum_cull_tb;

    import afc_pkg::*;

    localparam int MAX_PLANES   = MAX_PLANES_DEF;
    localparam int LAT_MARGIN   = 8;          // pipeline is five deep
    localparam int LIMIT_CYCLES = 400000;
    localparam int SET_WORDS    = 40;         // box words per random setting

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_F = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 3'd7;

    localparam int C_MIN = -(1 << (COORD_W - 1));
    localparam int C_MAX = (1 << (COORD_W - 1)) - 1;
    localparam int N_MIN = -(1 << (NORM_W - 1));
    localparam int N_MAX = (1 << (NORM_W - 1)) - 1;
    localparam int D_MIN = -(1 << (D_W - 1));
    localparam int D_MAX = (1 << (D_W - 1)) - 1;
    localparam int ONE_N = 1 << 10;           // 1.0 in Q2.10
    localparam int ONE_C = 1 << 8;            // 1.0 in Q16.8

    typedef enum logic [1:0] {
        ITEM_BOX,
        ITEM_WRITE,
        ITEM_DRAIN,
        ITEM_RATE
    } feed_kind_t;

    typedef struct {
        feed_kind_t              kind;
        box_t                    box;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        int                      pct;
    } feed_word_t;

    logic clk;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [COORD_W-1:0] min_x = '0;
    logic signed [COORD_W-1:0] min_y = '0;
    logic signed [COORD_W-1:0] min_z = '0;
    logic signed [COORD_W-1:0] max_x = '0;
    logic signed [COORD_W-1:0] max_y = '0;
    logic signed [COORD_W-1:0] max_z = '0;
    logic done;
    clip_class_t clip_class;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    feed_word_t  feed_q[$];
    clip_class_t class_q[$];
    int          class_pending = 0;
    int          quiet_cycles = 0;
    int          idle_pct = 0;
    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;

    // bench copy of the plane registers
    logic [PLANE_W-1:0] plane_reg [0:5];
    logic [COUNT_W-1:0] count_reg;

    aabb_frustum_cull #(
        .MAX_PLANES(MAX_PLANES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .min_x(min_x),
        .min_y(min_y),
        .min_z(min_z),
        .max_x(max_x),
        .max_y(max_y),
        .max_z(max_z),
        .done(done),
        .clip_class(clip_class),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // p/n-vertex classification against the leading planes
    function automatic clip_class_t classify_box(input box_t b);
        longint lo [3];
        longint hi [3];
        longint n_sum;
        longint p_sum;
        longint ofs;
        longint nrm;
        int     cnt;
        bit     cut;
        logic [PLANE_W-1:0] p;
        lo[0] = $signed(b.min_x);
        lo[1] = $signed(b.min_y);
        lo[2] = $signed(b.min_z);
        hi[0] = $signed(b.max_x);
        hi[1] = $signed(b.max_y);
        hi[2] = $signed(b.max_z);
        cnt = (count_reg > MAX_PLANES) ? MAX_PLANES : int'(count_reg);
        cut = 1'b0;
        for (int i = 0; i < cnt; i++)
        begin
            p = plane_reg[i];
            n_sum = 0;
            p_sum = 0;
            ofs = $signed(p[PLANE_W-1 -: D_W]);
            ofs = ofs * (longint'(1) << D_SHIFT);
            for (int a = 0; a < NUM_AXES; a++)
            begin
                nrm = $signed(p[NORM_W*a +: NORM_W]);
                // zero component counts as not positive
                if (nrm > 0)
                begin
                    n_sum += lo[a] * nrm;
                    p_sum += hi[a] * nrm;
                end
                else
                begin
                    n_sum += hi[a] * nrm;
                    p_sum += lo[a] * nrm;
                end
            end
            if (n_sum + ofs > 0)
                return CLASS_OUTSIDE;
            if (p_sum + ofs > 0)
                cut = 1'b1;
        end
        return cut ? CLASS_CUT : CLASS_INSIDE;
    endfunction

    function automatic logic [PLANE_W-1:0] pack_plane(input int nx, input int ny,
                                                      input int nz, input int dofs);
        return {dofs[D_W-1:0], nz[NORM_W-1:0], ny[NORM_W-1:0], nx[NORM_W-1:0]};
    endfunction

    function automatic box_t make_box(input int ax, input int ay, input int az,
                                      input int bx, input int by, input int bz);
        box_t b;
        b.min_x = ax[COORD_W-1:0];
        b.min_y = ay[COORD_W-1:0];
        b.min_z = az[COORD_W-1:0];
        b.max_x = bx[COORD_W-1:0];
        b.max_y = by[COORD_W-1:0];
        b.max_z = bz[COORD_W-1:0];
        return b;
    endfunction

    function automatic box_t rand_box();
        return make_box($urandom(), $urandom(), $urandom(),
                        $urandom(), $urandom(), $urandom());
    endfunction

    // box scattered around a frustum of half extent r units
    function automatic box_t near_box(input int r);
        int lo [3];
        int hi [3];
        int c;
        int h;
        int t;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            c = int'($urandom_range(0, 3 * r)) - (3 * r) / 2;
            if ($urandom_range(0, 3) == 0)
                h = $urandom_range(0, 4);
            else
                h = $urandom_range(0, r / 2);
            lo[a] = (c - h) * ONE_C - int'($urandom_range(0, 255));
            hi[a] = (c + h) * ONE_C + int'($urandom_range(0, 255));
            // occasional swapped corners
            if ($urandom_range(0, 15) == 0)
            begin
                t = lo[a];
                lo[a] = hi[a];
                hi[a] = t;
            end
        end
        return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endfunction

    task automatic add_box(input box_t b);
        feed_word_t w;
        w.kind = ITEM_BOX;
        w.box = b;
        w.idx = '0;
        w.data = '0;
        w.pct = 0;
        feed_q.push_back(w);
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        feed_word_t w;
        w.kind = ITEM_WRITE;
        w.box = '0;
        w.idx = idx;
        w.data = data;
        w.pct = 0;
        feed_q.push_back(w);
    endtask

    task automatic add_marker(input feed_kind_t kind, input int pct);
        feed_word_t w;
        w.kind = kind;
        w.box = '0;
        w.idx = '0;
        w.data = '0;
        w.pct = pct;
        feed_q.push_back(w);
    endtask

    // six slightly tilted planes bounding a cube of half extent r units
    task automatic add_frustum(input int r);
        int nc [3];
        int ax;
        for (int k = 0; k < 6; k++)
        begin
            ax = k / 2;
            for (int a = 0; a < NUM_AXES; a++)
                nc[a] = int'($urandom_range(0, 192)) - 96;
            nc[ax] = ONE_N - int'($urandom_range(0, 200));
            if (k % 2 == 1)
                nc[ax] = -nc[ax];
            add_write(REG_PLANE_A + k[CFG_IDX_W-1:0],
                      pack_plane(nc[0], nc[1], nc[2],
                                 -(r * ONE_C) - int'($urandom_range(0, 255))));
        end
    endtask

    // driver: presents box words and performs plane writes once idle
    always @(posedge clk or negedge rst_n)
    begin : drive
        box_t                  nb;
        logic                  ns;
        logic                  nwe;
        logic [CFG_IDX_W-1:0]  nidx;
        logic [CFG_DATA_W-1:0] ndata;
        bit                    holding;
        if (!rst_n)
        begin
            start     <= 1'b0;
            cfg_we    <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
            min_x     <= '0;
            min_y     <= '0;
            min_z     <= '0;
            max_x     <= '0;
            max_y     <= '0;
            max_z     <= '0;
            quiet_cycles = 0;
        end
        else
        begin
            nb = {min_x, min_y, min_z, max_x, max_y, max_z};
            ns = 1'b0;
            nwe = 1'b0;
            nidx = cfg_index;
            ndata = cfg_data;
            holding = 1'b0;

            // word taken at this edge
            if (start)
            begin
                if (!busy)
                    feed_q.delete(0);
                else
                    holding = 1'b1;
            end

            // idle time counts only with nothing in flight
            if (start || class_pending != 0)
                quiet_cycles = 0;
            else if (quiet_cycles < LAT_MARGIN)
                quiet_cycles++;

            while (feed_q.size() != 0 && feed_q[0].kind == ITEM_RATE)
            begin
                idle_pct = feed_q[0].pct;
                feed_q.delete(0);
            end

            if (holding)
                ns = 1'b1;
            else if (feed_q.size() != 0)
            begin
                case (feed_q[0].kind)
                    ITEM_BOX:
                    begin
                        if (int'($urandom_range(0, 99)) >= idle_pct)
                        begin
                            ns = 1'b1;
                            nb = feed_q[0].box;
                        end
                    end
                    ITEM_WRITE:
                    begin
                        if (quiet_cycles >= LAT_MARGIN)
                        begin
                            nwe = 1'b1;
                            nidx = feed_q[0].idx;
                            ndata = feed_q[0].data;
                            feed_q.delete(0);
                        end
                    end
                    ITEM_DRAIN:
                    begin
                        if (quiet_cycles >= LAT_MARGIN)
                            feed_q.delete(0);
                    end
                    default:
                    begin
                    end
                endcase
            end

            start     <= ns;
            cfg_we    <= nwe;
            cfg_index <= nidx;
            cfg_data  <= ndata;
            min_x     <= nb.min_x;
            min_y     <= nb.min_y;
            min_z     <= nb.min_z;
            max_x     <= nb.max_x;
            max_y     <= nb.max_y;
            max_z     <= nb.max_z;
        end
    end

    // monitor: checks results, predicts accepted words, tracks plane writes
    always @(posedge clk or negedge rst_n)
    begin : watch
        clip_class_t want;
        box_t        taken;
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                plane_reg[i] = '0;
            count_reg = PLANES_USED_RST;
            class_q.delete();
            class_pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (class_q.size() == 0)
                begin
                    $error("result word with no pending box: clip_class %0d", clip_class);
                    mismatch_cnt++;
                end
                else
                begin
                    want = class_q.pop_front();
                    if (clip_class !== want)
                    begin
                        $error("clip_class: expected %0d, actual %0d", want, clip_class);
                        mismatch_cnt++;
                    end
                end
            end

            if (start && !busy)
            begin
                taken = {min_x, min_y, min_z, max_x, max_y, max_z};
                class_q.push_back(classify_box(taken));
            end

            // unknown index is ignored
            if (cfg_we)
            begin
                if (cfg_index <= REG_PLANE_F)
                    plane_reg[cfg_index] = cfg_data;
                else if (cfg_index == REG_PLANES_USED)
                    count_reg = cfg_data[COUNT_W-1:0];
            end

            class_pending <= class_q.size();
        end
    end

    // run limit
    initial
    begin
        while (cycle_cnt < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Mismatches found");
        $finish;
    end

    // stimulus and end of run
    initial
    begin : stimulus
        int r;
        int mode;
        int v;
        int rates [3];
        rates[0] = 8;
        rates[1] = 86;
        rates[2] = 0;

        // reset planes are all zero: every sum is exactly zero
        add_marker(ITEM_RATE, 0);
        add_box(make_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
        add_box(make_box(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN));

        // exact axis aligned cube of half extent 1000
        add_write(REG_PLANE_A + 3'd0, pack_plane(ONE_N, 0, 0, -1000 * ONE_C));
        add_write(REG_PLANE_A + 3'd1, pack_plane(-ONE_N, 0, 0, -1000 * ONE_C));
        add_write(REG_PLANE_A + 3'd2, pack_plane(0, ONE_N, 0, -1000 * ONE_C));
        add_write(REG_PLANE_A + 3'd3, pack_plane(0, -ONE_N, 0, -1000 * ONE_C));
        add_write(REG_PLANE_A + 3'd4, pack_plane(0, 0, ONE_N, -1000 * ONE_C));
        add_write(REG_PLANE_F, pack_plane(0, 0, -ONE_N, -1000 * ONE_C));
        add_write(REG_PLANES_USED, 64'd6);
        add_box(make_box(-10 * ONE_C, -10 * ONE_C, -10 * ONE_C,
                         10 * ONE_C, 10 * ONE_C, 10 * ONE_C));
        add_box(make_box(900 * ONE_C, 0, 0, 1100 * ONE_C, ONE_C, ONE_C));
        add_box(make_box(1100 * ONE_C, 0, 0, 1200 * ONE_C, ONE_C, ONE_C));
        // faces touching the plane exactly
        add_box(make_box(0, 0, 0, 1000 * ONE_C, ONE_C, ONE_C));
        add_box(make_box(1000 * ONE_C, 0, 0, 1001 * ONE_C, ONE_C, ONE_C));
        add_box(make_box(-1000 * ONE_C, 0, 0, 0, ONE_C, ONE_C));
        add_box(make_box(500 * ONE_C, 0, 0, -500 * ONE_C, ONE_C, ONE_C));
        add_box(make_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));

        // plane count: side planes only, partial, all six, none, above the maximum
        for (int c = 0; c < 8; c++)
        begin
            add_write(REG_PLANES_USED, 64'(c));
            if (c == 1 || c == 7)
                add_box(make_box(1100 * ONE_C, 0, 0, 1200 * ONE_C, ONE_C, ONE_C));
            else
                add_box(make_box(0, 0, 1100 * ONE_C, ONE_C, ONE_C, 1200 * ONE_C));
        end

        // extreme normals and offsets
        add_write(REG_PLANE_A, pack_plane(N_MAX, N_MIN, 0, D_MAX));
        add_write(REG_PLANE_B, pack_plane(N_MIN, N_MAX, N_MIN, D_MIN));
        add_write(REG_PLANES_USED, 64'd2);
        add_box(make_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
        add_box(make_box(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN));
        add_box(make_box(0, 0, 0, 0, 0, 0));

        // unmapped index leaves the planes alone
        add_write(REG_SPARE, '1);
        add_box(make_box(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN));

        // random settings under three sender rates
        for (int ph = 0; ph < 3; ph++)
        begin
            add_marker(ITEM_RATE, rates[ph]);
            for (int s = 0; s < 9; s++)
            begin
                mode = $urandom_range(0, 3);
                r = $urandom_range(50, 12000);
                if (mode == 0)
                begin
                    for (int k = 0; k < 6; k++)
                        add_write(REG_PLANE_A + k[CFG_IDX_W-1:0], {$urandom(), $urandom()});
                end
                else
                    add_frustum(r);
                v = $urandom_range(0, 11);
                add_write(REG_PLANES_USED, 64'((v < 8) ? v : 4 + v % 3));
                if ($urandom_range(0, 3) == 0)
                    add_write(REG_SPARE, {$urandom(), $urandom()});
                for (int n = 0; n < SET_WORDS; n++)
                begin
                    // sender waits for every result to come back
                    if (n == SET_WORDS / 2 && ((ph == 0 && s == 0) || $urandom_range(0, 1) == 0))
                        add_marker(ITEM_DRAIN, 0);
                    if (mode == 0)
                        add_box(($urandom_range(0, 1) == 0) ? rand_box() : near_box(12000));
                    else
                        add_box(($urandom_range(0, 9) == 0) ? rand_box() : near_box(r));
                end
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (feed_q.size() != 0 || start || class_pending != 0);
        repeat (4 * LAT_MARGIN) @(posedge clk);

        if (class_q.size() != 0)
        begin
            $error("%0d box words never produced a result", class_q.size());
            mismatch_cnt++;
        end

        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
